// ----- sv/dltq_pkg.sv -----
// shared types and constants for the delta-list timer queue
`default_nettype none
package dltq_pkg;

    localparam int SLOTS   = 16;
    localparam int IDX_W   = 6;
    localparam int TAG_W   = 8;
    localparam int ID_W    = 4;
    localparam int TIME_W  = 32;
    localparam int AMT_W   = 16;
    localparam int RES_W   = 5;

    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_ADD      = 2'd1;
    localparam logic [1:0] OP_DELETE   = 2'd2;
    localparam logic [1:0] OP_DISPATCH = 2'd3;

    localparam logic [AMT_W-1:0] TICK_RESET = 16'd10;

    typedef struct packed {
        logic [1:0]        operation;
        logic [TAG_W-1:0]  task_tag;
        logic [TIME_W-1:0] delay;
        logic [TIME_W-1:0] period;
        logic [ID_W-1:0]   task_id;
    } req_word_t;

    typedef struct packed {
        logic [RES_W-1:0] result_value;
        logic             run_valid;
        logic [TAG_W-1:0] run_tag;
    } rsp_word_t;

    typedef struct packed {
        logic              used;
        logic              ready;
        logic [TAG_W-1:0]  tag;
        logic [ID_W-1:0]   ident;
        logic [TIME_W-1:0] delta;
        logic [TIME_W-1:0] period;
    } slot_t;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_TICK,
        CMD_INS,
        CMD_DEL
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [IDX_W-1:0]  idx;
        logic              split;
        logic [TAG_W-1:0]  tag;
        logic [ID_W-1:0]   ident;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] delta;
        logic [TIME_W-1:0] rest;
        logic [AMT_W-1:0]  amount;
    } cmd_t;

endpackage
`default_nettype wire

// ----- sv/dltq_cell.sv -----
// one slot of the delta list, shifts with its neighbors on insert and delete
`default_nettype none
module dltq_cell #(
    parameter int IDX   = 0
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire dltq_pkg::cmd_t  cmd,
    input  wire dltq_pkg::slot_t left_slot,
    input  wire dltq_pkg::slot_t right_slot,
    output dltq_pkg::slot_t      slot
);
    import dltq_pkg::*;

    localparam logic [IDX_W-1:0] MY = IDX_W'(IDX);
    localparam bit IS_LAST = (IDX == SLOTS - 1);
    localparam slot_t SLOT_RESET = '{used: 1'b0, ready: 1'b0, tag: '0,
                                     ident: ID_W'(SLOTS - 1 - IDX),
                                     delta: '0, period: '0};

    slot_t s_reg;
    slot_t s_next;
    logic [TIME_W-1:0] tick_amt;
    logic [TIME_W-1:0] ins_delta;

    assign tick_amt = TIME_W'(cmd.amount);

    always_comb
    begin
        s_next = s_reg;
        ins_delta = cmd.delta;
        if (cmd.split && !IS_LAST)
        begin
            ins_delta = s_reg.delta - cmd.rest;
        end
        unique case (cmd.kind)
            CMD_TICK:
            begin
                if (IDX == 0 && s_reg.used)
                begin
                    if (s_reg.delta > tick_amt)
                        s_next.delta = s_reg.delta - tick_amt;
                    else
                        s_next.delta = '0;
                    if (s_next.delta == '0)
                        s_next.ready = 1'b1;
                end
            end
            CMD_INS:
            begin
                if (MY > cmd.idx)
                begin
                    s_next = left_slot;
                    // successor of a split slot keeps the remainder
                    if (MY == IDX_W'(cmd.idx + 1'b1) && cmd.split)
                    begin
                        s_next.delta = cmd.rest;
                        if (cmd.rest == '0)
                            s_next.ready = 1'b1;
                    end
                end
                else if (MY == cmd.idx)
                begin
                    s_next.used   = 1'b1;
                    s_next.tag    = cmd.tag;
                    s_next.ident  = cmd.ident;
                    s_next.period = cmd.period;
                    s_next.delta  = ins_delta;
                    s_next.ready  = (ins_delta == '0);
                end
            end
            CMD_DEL:
            begin
                if (IS_LAST && MY >= cmd.idx)
                begin
                    s_next        = '0;
                    s_next.ident  = cmd.ident;
                end
                else if (MY == cmd.idx)
                begin
                    s_next = right_slot;
                    // fold the removed delta into a used successor
                    if (right_slot.used)
                        s_next.delta = right_slot.delta + s_reg.delta;
                end
                else if (MY > cmd.idx)
                begin
                    s_next = right_slot;
                end
            end
            default:
            begin
                s_next = s_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_reg <= SLOT_RESET;
        end
        else
        begin
            s_reg <= s_next;
        end
    end

    assign slot = s_reg;

endmodule
`default_nettype wire

// ----- sv/dltq_ctrl.sv -----
// sequencer: walks the slot row and issues shift commands to the cells
`default_nettype none
module dltq_ctrl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       req_valid,
    output logic                            req_stall,
    input  wire dltq_pkg::req_word_t         req_word,
    output logic                            rsp_valid,
    input  wire logic                       rsp_stall,
    output dltq_pkg::rsp_word_t              rsp_word,
    input  wire logic                       cfg_write,
    input  wire logic [dltq_pkg::AMT_W-1:0] cfg_data,
    input  wire dltq_pkg::slot_t             slots [dltq_pkg::SLOTS],
    output dltq_pkg::cmd_t                   cmd
);
    import dltq_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int AW = TIME_W + IW + 1;
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_PREP,
        S_ADD_SCAN,
        S_DEL_SCAN,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [AW-1:0]     acc_reg, acc_next;
    logic [TAG_W-1:0]  tag_reg, tag_next;
    logic [TIME_W-1:0] delay_reg, delay_next;
    logic [TIME_W-1:0] period_reg, period_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic              disp_reg, disp_next;
    logic [RES_W-1:0]  res_reg, res_next;
    logic              runv_reg, runv_next;
    logic [TAG_W-1:0]  runtag_reg, runtag_next;
    logic [AMT_W-1:0]  amount_reg, amount_next;
    logic              out_valid_reg, out_valid_next;
    rsp_word_t         out_word_reg, out_word_next;

    slot_t         sel;
    slot_t         last_slot;
    logic [AW-1:0] acc_sum;
    logic [AW-1:0] delay_ext;
    logic          over;
    logic          accept;

    assign sel       = slots[idx_reg];
    assign last_slot = slots[SLOTS-1];
    assign delay_ext = AW'(delay_reg);
    assign acc_sum   = acc_reg + AW'(sel.delta);
    assign over      = acc_sum > delay_ext;
    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        acc_next       = acc_reg;
        tag_next       = tag_reg;
        delay_next     = delay_reg;
        period_next    = period_reg;
        id_next        = id_reg;
        disp_next      = disp_reg;
        res_next       = res_reg;
        runv_next      = runv_reg;
        runtag_next    = runtag_reg;
        amount_next    = amount_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        cmd            = '0;
        cmd.kind       = CMD_NONE;

        if (cfg_write)
            amount_next = cfg_data;
        if (out_valid_reg && !rsp_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next    = '0;
                    runv_next   = 1'b0;
                    runtag_next = '0;
                    disp_next   = 1'b0;
                    idx_next    = '0;
                    acc_next    = '0;
                    unique case (req_word.operation)
                        OP_TICK:
                        begin
                            cmd.kind   = CMD_TICK;
                            cmd.amount = amount_reg;
                            state_next = S_DONE;
                        end
                        OP_ADD:
                        begin
                            tag_next    = req_word.task_tag;
                            delay_next  = req_word.delay;
                            period_next = req_word.period;
                            state_next  = S_ADD_PREP;
                        end
                        OP_DELETE:
                        begin
                            id_next    = req_word.task_id;
                            state_next = S_DEL_SCAN;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                            if (slots[0].used && slots[0].ready)
                            begin
                                cmd.kind    = CMD_DEL;
                                cmd.idx     = '0;
                                cmd.ident   = slots[0].ident;
                                runv_next   = 1'b1;
                                runtag_next = slots[0].tag;
                                // periodic task goes back in with delay = period
                                if (slots[0].period != '0)
                                begin
                                    tag_next    = slots[0].tag;
                                    delay_next  = slots[0].period;
                                    period_next = slots[0].period;
                                    disp_next   = 1'b1;
                                    state_next  = S_ADD_PREP;
                                end
                            end
                        end
                    endcase
                end
            end
            S_ADD_PREP:
            begin
                if (last_slot.used)
                begin
                    if (!disp_reg)
                        res_next = RES_W'(SLOTS);
                    state_next = S_DONE;
                end
                else
                begin
                    id_next    = last_slot.ident;
                    idx_next   = '0;
                    acc_next   = '0;
                    state_next = S_ADD_SCAN;
                end
            end
            S_ADD_SCAN:
            begin
                if (over || !sel.used)
                begin
                    cmd.kind   = CMD_INS;
                    cmd.idx    = IDX_W'(idx_reg);
                    cmd.split  = over;
                    cmd.tag    = tag_reg;
                    cmd.ident  = id_reg;
                    cmd.period = period_reg;
                    cmd.rest   = TIME_W'(acc_sum - delay_ext);
                    cmd.delta  = over ? '0 : TIME_W'(delay_ext - acc_sum);
                    if (!disp_reg)
                        res_next = RES_W'(id_reg);
                    state_next = S_DONE;
                end
                else if (idx_reg == LAST)
                begin
                    if (!disp_reg)
                        res_next = RES_W'(SLOTS);
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    acc_next = acc_sum;
                end
            end
            S_DEL_SCAN:
            begin
                if (sel.ident == id_reg)
                begin
                    cmd.kind   = CMD_DEL;
                    cmd.idx    = IDX_W'(idx_reg);
                    cmd.ident  = id_reg;
                    res_next   = RES_W'(1);
                    state_next = S_DONE;
                end
                else if (idx_reg == LAST)
                begin
                    res_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_valid_next             = 1'b1;
                    out_word_next.result_value = res_reg;
                    out_word_next.run_valid    = runv_reg;
                    out_word_next.run_tag      = runtag_reg;
                    state_next                 = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            acc_reg       <= '0;
            tag_reg       <= '0;
            delay_reg     <= '0;
            period_reg    <= '0;
            id_reg        <= '0;
            disp_reg      <= 1'b0;
            res_reg       <= '0;
            runv_reg      <= 1'b0;
            runtag_reg    <= '0;
            amount_reg    <= TICK_RESET;
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            acc_reg       <= acc_next;
            tag_reg       <= tag_next;
            delay_reg     <= delay_next;
            period_reg    <= period_next;
            id_reg        <= id_next;
            disp_reg      <= disp_next;
            res_reg       <= res_next;
            runv_reg      <= runv_next;
            runtag_reg    <= runtag_next;
            amount_reg    <= amount_next;
            out_valid_reg <= out_valid_next;
            out_word_reg  <= out_word_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_word  = out_word_reg;

endmodule
`default_nettype wire

// ----- sv/delta_list_task_timer_queue.sv -----
// Delta-list task timer queue: SLOTS task slots kept in firing order,
// each holding its delay relative to the slot before it.
// req channel (req_valid/req_stall/req_word) takes one operation word:
// tick, add, delete or dispatch. rsp channel (rsp_valid/rsp_stall/rsp_word)
// returns exactly one result word per operation, in order.
// cfg_write/cfg_data load the tick amount (reset value 10); the user must
// load it only while idle, as the block itself does not enforce this.
// Acceptance to result word in the output register: tick and one-shot
// dispatch go straight to the done state; delete walks the slot row (one
// slot compared per cycle); add passes a prep state and, if a slot is free,
// walks the row (one slot delta summed per cycle); periodic dispatch runs
// the same re-insertion walk. One operation is in flight at a time; req_stall
// is high from acceptance until the result is placed in the output register.
// Reset empties every slot and gives slot k the id SLOTS-1-k.
// While rsp_stall holds, the result word stays in the output register; the
// next operation may still be taken, but its result waits for that register.
`default_nettype none
module delta_list_task_timer_queue (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       req_valid,
    output logic                            req_stall,
    input  wire dltq_pkg::req_word_t         req_word,
    output logic                            rsp_valid,
    input  wire logic                       rsp_stall,
    output dltq_pkg::rsp_word_t              rsp_word,
    input  wire logic                       cfg_write,
    input  wire logic [dltq_pkg::AMT_W-1:0] cfg_data
);
    import dltq_pkg::*;

    slot_t slot_q [SLOTS];
    cmd_t  cmd;

    dltq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .slots     (slot_q),
        .cmd       (cmd)
    );

    for (genvar k = 0; k < SLOTS; k++)
    begin : g_cell
        slot_t left_s;
        slot_t right_s;

        if (k == 0)
        begin : g_first
            assign left_s = '0;
        end
        else
        begin : g_mid_l
            assign left_s = slot_q[k-1];
        end

        if (k == SLOTS - 1)
        begin : g_end
            assign right_s = '0;
        end
        else
        begin : g_mid_r
            assign right_s = slot_q[k+1];
        end

        dltq_cell #(
            .IDX  (k)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .left_slot  (left_s),
            .right_slot (right_s),
            .slot       (slot_q[k])
        );
    end

endmodule
`default_nettype wire
